// ===== src/ecc_pkg.sv =====
// Shared types, codes and lookup functions of the EBNF character classifier.
// No dependencies; imported by every module of the block.
package ecc_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF   = 4;

    // Result status codes
    localparam logic [1:0] STATUS_TOKEN = 2'd0;
    localparam logic [1:0] STATUS_ERROR = 2'd1;
    localparam logic [1:0] STATUS_DONE  = 2'd2;

    // Character class codes
    localparam logic [4:0] CLS_TERMINATOR   = 5'd0;
    localparam logic [4:0] CLS_LETTER       = 5'd1;
    localparam logic [4:0] CLS_DIGIT        = 5'd2;
    localparam logic [4:0] CLS_QUOTE_SINGLE = 5'd3;
    localparam logic [4:0] CLS_QUOTE_DOUBLE = 5'd4;
    localparam logic [4:0] CLS_CONCAT       = 5'd5;
    localparam logic [4:0] CLS_DEFINE       = 5'd6;
    localparam logic [4:0] CLS_OPTION_END   = 5'd7;
    localparam logic [4:0] CLS_DEF_SEP      = 5'd8;
    localparam logic [4:0] CLS_EXCEPT       = 5'd9;
    localparam logic [4:0] CLS_COMMENT_END  = 5'd10;
    localparam logic [4:0] CLS_REPETITION   = 5'd11;
    localparam logic [4:0] CLS_COMMENT_BEG  = 5'd12;
    localparam logic [4:0] CLS_REPEAT_BEG   = 5'd13;
    localparam logic [4:0] CLS_REPEAT_END   = 5'd14;
    localparam logic [4:0] CLS_OPTION_BEG   = 5'd15;
    localparam logic [4:0] CLS_GROUP_BEG    = 5'd16;
    localparam logic [4:0] CLS_GROUP_END    = 5'd17;
    localparam logic [4:0] CLS_SPECIAL      = 5'd18;
    localparam logic [4:0] CLS_OTHER        = 5'd19;
    localparam logic [4:0] CLS_SPACE        = 5'd20;
    localparam logic [4:0] CLS_HTAB         = 5'd21;
    localparam logic [4:0] CLS_NEWLINE      = 5'd22;
    localparam logic [4:0] CLS_VTAB         = 5'd23;
    localparam logic [4:0] CLS_FORMFEED     = 5'd24;

    // Bytes with a role of their own
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_NL     = 8'h0A;

    // Kind of a held pair opener
    typedef enum logic [1:0] {
        KIND_PAREN = 2'd0,
        KIND_STAR  = 2'd1,
        KIND_COLON = 2'd2,
        KIND_SLASH = 2'd3
    } t_kind;

    typedef struct packed {
        logic       valid;
        logic [4:0] cls;
    } t_class_hit;

    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_kind_hit;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  char_class;
        logic [1:0]  token_length;
        logic [7:0]  first_byte;
        logic [7:0]  second_byte;
        logic [15:0] error_line;
        logic [15:0] error_column;
    } t_result;

    // One queue entry: an optional lone opener, then an optional main result
    typedef struct packed {
        logic    flush_valid;
        t_kind   flush_kind;
        logic    main_valid;
        t_result main;
    } t_cmd;

    function automatic logic [7:0] opener_byte(t_kind kind);
        logic [7:0] b;
        unique case (kind)
            KIND_PAREN: b = CH_LPAREN;
            KIND_STAR:  b = CH_STAR;
            KIND_COLON: b = CH_COLON;
            KIND_SLASH: b = CH_SLASH;
            default:    b = CH_LPAREN;
        endcase
        return b;
    endfunction

    function automatic logic [4:0] opener_class(t_kind kind);
        logic [4:0] c;
        unique case (kind)
            KIND_PAREN: c = CLS_GROUP_BEG;
            KIND_STAR:  c = CLS_REPETITION;
            KIND_COLON: c = CLS_OTHER;
            KIND_SLASH: c = CLS_DEF_SEP;
            default:    c = CLS_GROUP_BEG;
        endcase
        return c;
    endfunction

    function automatic t_kind_hit opener_kind(logic [7:0] b);
        t_kind_hit r;
        r.valid = 1'b1;
        r.kind  = KIND_PAREN;
        unique case (b)
            CH_LPAREN: r.kind = KIND_PAREN;
            CH_STAR:   r.kind = KIND_STAR;
            CH_COLON:  r.kind = KIND_COLON;
            CH_SLASH:  r.kind = KIND_SLASH;
            default:   r.valid = 1'b0;
        endcase
        return r;
    endfunction

    function automatic t_class_hit single_class(logic [7:0] b);
        t_class_hit r;
        r.valid = 1'b1;
        r.cls   = CLS_TERMINATOR;
        if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) begin
            r.cls = CLS_LETTER;
        end else if (b >= 8'h30 && b <= 8'h39) begin
            r.cls = CLS_DIGIT;
        end else begin
            unique case (b)
                8'h3B, 8'h2E: r.cls = CLS_TERMINATOR;   // ; .
                8'h27:        r.cls = CLS_QUOTE_SINGLE;
                8'h22:        r.cls = CLS_QUOTE_DOUBLE;
                8'h2C:        r.cls = CLS_CONCAT;
                8'h3D:        r.cls = CLS_DEFINE;
                8'h5D:        r.cls = CLS_OPTION_END;
                8'h7C, 8'h21: r.cls = CLS_DEF_SEP;      // | !
                8'h2D:        r.cls = CLS_EXCEPT;
                8'h7B:        r.cls = CLS_REPEAT_BEG;
                8'h7D:        r.cls = CLS_REPEAT_END;
                8'h5B:        r.cls = CLS_OPTION_BEG;
                CH_RPAREN:    r.cls = CLS_GROUP_END;
                8'h3F:        r.cls = CLS_SPECIAL;
                // + _ % @ & # $ < > \ ^ ` ~
                8'h2B, 8'h5F, 8'h25, 8'h40, 8'h26, 8'h23, 8'h24,
                8'h3C, 8'h3E, 8'h5C, 8'h5E, 8'h60, 8'h7E:
                              r.cls = CLS_OTHER;
                8'h20:        r.cls = CLS_SPACE;
                8'h09:        r.cls = CLS_HTAB;
                CH_NL:        r.cls = CLS_NEWLINE;
                8'h0B:        r.cls = CLS_VTAB;
                8'h0C:        r.cls = CLS_FORMFEED;
                default:      r.valid = 1'b0;
            endcase
        end
        return r;
    endfunction

    function automatic t_class_hit pair_class(t_kind kind, logic [7:0] b);
        t_class_hit r;
        r.valid = 1'b0;
        r.cls   = CLS_TERMINATOR;
        if (kind == KIND_PAREN) begin
            r.valid = 1'b1;
            unique case (b)
                CH_STAR:  r.cls = CLS_COMMENT_BEG;
                CH_COLON: r.cls = CLS_REPEAT_BEG;
                CH_SLASH: r.cls = CLS_OPTION_BEG;
                default:  r.valid = 1'b0;
            endcase
        end else if (b == CH_RPAREN) begin
            r.valid = 1'b1;
            unique case (kind)
                KIND_STAR:  r.cls = CLS_COMMENT_END;
                KIND_COLON: r.cls = CLS_REPEAT_END;
                default:    r.cls = CLS_OPTION_END;
            endcase
        end
        return r;
    endfunction

endpackage

// ===== src/ebnf_char_classifier.sv =====
// Top level of the EBNF character classifier: front end, command queue and
// back end. Depends on ecc_pkg, ecc_front, ecc_queue and ecc_back.
//
// The block reads EBNF source one byte per word on the slave stream and
// returns one result word per token, error or end of text on the master
// stream. A byte that may open a two-byte token, ( * : /, is held for one
// word and joined with the next byte into (* *) (: :) (/ /); otherwise it is
// sent alone ahead of the next byte's result. Line and column of each byte
// are counted and saturate; an invalid byte gives an error word with its
// position, while end of text (tlast, or a NUL byte) gives a done word. After
// either the block swallows all input words without result until reset.
// Rate: one byte is taken every cycle. The back end sends one result word a
// cycle while the master side is ready, so a byte that causes two results
// holds it for both words; a queue of QUEUE_DEPTH commands between front and
// back absorbs these, and the input stalls only when that queue fills. A
// result word passes through the queue and the back end's output register
// before it is presented on the master side; back-pressure delays it further.
module ebnf_char_classifier
    import ecc_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [4:0] char_class, [6:5] token_length, [14:7] first_byte,
    // [22:15] second_byte, [38:23] error_line, [54:39] error_column, [55] zero
    output logic [55:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast    // last_result
);

    logic    w_push, w_full;
    t_cmd    w_push_cmd;
    logic    w_q_valid, w_pop;
    t_cmd    w_q_cmd;
    t_result w_res;

    // Classify bytes, hold openers, track position
    ecc_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_eot   (s_axis_tlast),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    // Decouple the byte side from output back-pressure
    ecc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_pop)
    );

    // Expand commands into result words
    ecc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_cmd_pop   (w_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_result    (w_res),
        .o_last      (m_axis_tlast)
    );

    // Pack the result word, lowest field first
    assign m_axis_tdata = {1'b0, w_res.error_column, w_res.error_line,
                           w_res.second_byte, w_res.first_byte,
                           w_res.token_length, w_res.char_class};
    assign m_axis_tuser = w_res.status;

endmodule

// ===== src/ecc_front.sv =====
// Front end: accepts source bytes, pairs openers, tracks position and halt,
// and pushes one command per byte that causes results. Uses ecc_pkg.
module ecc_front
    import ecc_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_eot,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    logic                     r_pend_valid, n_pend_valid;
    t_kind                    r_pend_kind, n_pend_kind;
    logic [POSITION_BITS-1:0] r_line, n_line;
    logic [POSITION_BITS-1:0] r_col, n_col;
    logic                     r_halted, n_halted;

    logic       w_accept;
    logic       w_advance;
    t_class_hit w_single;
    t_class_hit w_pair;
    t_kind_hit  w_open;
    logic [15:0] w_err_line, w_err_col;
    t_cmd       w_cmd;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;
    assign w_single = single_class(i_byte);
    assign w_pair   = pair_class(r_pend_kind, i_byte);
    assign w_open   = opener_kind(i_byte);

    // Clip the position to the 16-bit report fields
    always_comb begin
        if (POSITION_BITS > 16 && r_line > POSITION_BITS'(17'h0FFFF)) begin
            w_err_line = 16'hFFFF;
        end else begin
            w_err_line = 16'(r_line);
        end
        if (POSITION_BITS > 16 && r_col > POSITION_BITS'(17'h0FFFF)) begin
            w_err_col = 16'hFFFF;
        end else begin
            w_err_col = 16'(r_col);
        end
    end

    always_comb begin
        n_pend_valid = r_pend_valid;
        n_pend_kind  = r_pend_kind;
        n_halted     = r_halted;
        w_advance    = 1'b0;
        w_cmd        = '0;
        w_cmd.flush_kind = r_pend_kind;

        if (w_accept && !r_halted) begin
            if (i_eot || i_byte == CH_NUL) begin
                w_cmd.flush_valid      = r_pend_valid;
                w_cmd.main_valid       = 1'b1;
                w_cmd.main.status      = STATUS_DONE;
                n_pend_valid = 1'b0;
                n_pend_kind  = KIND_PAREN;
                n_halted     = 1'b1;
            end else if (r_pend_valid && w_pair.valid) begin
                w_cmd.main_valid        = 1'b1;
                w_cmd.main.status       = STATUS_TOKEN;
                w_cmd.main.char_class   = w_pair.cls;
                w_cmd.main.token_length = 2'd2;
                w_cmd.main.first_byte   = opener_byte(r_pend_kind);
                w_cmd.main.second_byte  = i_byte;
                n_pend_valid = 1'b0;
                n_pend_kind  = KIND_PAREN;
                w_advance    = 1'b1;
            end else begin
                // Emit the held opener alone, then handle the new byte
                w_cmd.flush_valid = r_pend_valid;
                if (w_open.valid) begin
                    n_pend_valid = 1'b1;
                    n_pend_kind  = w_open.kind;
                    w_advance    = 1'b1;
                end else if (w_single.valid) begin
                    w_cmd.main_valid        = 1'b1;
                    w_cmd.main.status       = STATUS_TOKEN;
                    w_cmd.main.char_class   = w_single.cls;
                    w_cmd.main.token_length = 2'd1;
                    w_cmd.main.first_byte   = i_byte;
                    n_pend_valid = 1'b0;
                    n_pend_kind  = KIND_PAREN;
                    w_advance    = 1'b1;
                end else begin
                    w_cmd.main_valid         = 1'b1;
                    w_cmd.main.status        = STATUS_ERROR;
                    w_cmd.main.first_byte    = i_byte;
                    w_cmd.main.error_line    = w_err_line;
                    w_cmd.main.error_column  = w_err_col;
                    n_pend_valid = 1'b0;
                    n_pend_kind  = KIND_PAREN;
                    n_halted     = 1'b1;
                end
            end
        end
    end

    // Saturating position of the next byte
    always_comb begin
        n_line = r_line;
        n_col  = r_col;
        if (w_advance) begin
            if (i_byte == CH_NL) begin
                if (r_line != POS_MAX) begin
                    n_line = r_line + POS_ONE;
                end
                n_col = POS_ONE;
            end else if (r_col != POS_MAX) begin
                n_col = r_col + POS_ONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_pend_kind  <= KIND_PAREN;
            r_line       <= POS_ONE;
            r_col        <= POS_ONE;
            r_halted     <= 1'b0;
        end else begin
            r_pend_valid <= n_pend_valid;
            r_pend_kind  <= n_pend_kind;
            r_line       <= n_line;
            r_col        <= n_col;
            r_halted     <= n_halted;
        end
    end

    assign o_push = w_accept && !r_halted && (w_cmd.flush_valid || w_cmd.main_valid);
    assign o_cmd  = w_cmd;

endmodule

// ===== src/ecc_queue.sv =====
// Short command queue between front and back end.
// Uses t_cmd from ecc_pkg.
module ecc_queue
    import ecc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          w_do_push, w_do_pop;

    assign o_full    = (r_count == FULL_CNT);
    assign o_valid   = (r_count != '0);
    assign o_cmd     = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + AW'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + AW'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CNT_ONE;
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - CNT_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== src/ecc_back.sv =====
// Back end: expands each queued command into one or two result words and
// holds them in the output register. Uses ecc_pkg.
module ecc_back
    import ecc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result,
    output logic    o_last
);

    logic    r_out_valid;
    t_result r_out_res;
    logic    r_out_last;
    logic    r_second;      // lone opener of the head command already sent

    logic    w_load;
    logic    w_flush_now;
    logic    w_is_last;
    t_result w_flush_res;
    t_result w_cur;

    assign w_load      = !r_out_valid || i_ready;
    assign w_flush_now = i_cmd.flush_valid && !r_second;
    assign w_is_last   = !(w_flush_now && i_cmd.main_valid);

    always_comb begin
        w_flush_res              = '0;
        w_flush_res.status       = STATUS_TOKEN;
        w_flush_res.char_class   = opener_class(i_cmd.flush_kind);
        w_flush_res.token_length = 2'd1;
        w_flush_res.first_byte   = opener_byte(i_cmd.flush_kind);
        w_cur = w_flush_now ? w_flush_res : i_cmd.main;
    end

    assign o_cmd_pop = w_load && i_cmd_valid && w_is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_second    <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= i_cmd_valid;
            if (i_cmd_valid) begin
                r_second <= !w_is_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_cmd_valid) begin
            r_out_res  <= w_cur;
            r_out_last <= w_is_last;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out_res;
    assign o_last   = r_out_last;

endmodule
